// ===== rtl/topq_pkg.sv =====
package topq_pkg;

	localparam int unsigned ActionFieldW = 2;
	localparam int unsigned IdFieldW     = 16;
	localparam int unsigned TimeFieldW   = 32;
	localparam int unsigned StatusFieldW = 2;
	localparam int unsigned CountFieldW  = 6;

	typedef enum logic [ActionFieldW-1:0] {
		OP_ENQ    = 2'd0,
		OP_DEQ    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [StatusFieldW-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic fire;
		op_t  op;
		logic full;
	} cell_ctl_t;

endpackage

// ===== rtl/topq_req_if.sv =====
interface topq_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [topq_pkg::ActionFieldW-1:0]    action;
	logic [topq_pkg::IdFieldW-1:0]        entry_id;
	logic [topq_pkg::TimeFieldW-1:0]      entry_time;

	modport source (output valid, action, entry_id, entry_time, input ready);
	modport sink (input valid, action, entry_id, entry_time, output ready);
endinterface

// ===== rtl/topq_rsp_if.sv =====
interface topq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [topq_pkg::IdFieldW-1:0]        result_id;
	logic [topq_pkg::TimeFieldW-1:0]      result_time;
	logic                                 id_found;
	logic [topq_pkg::StatusFieldW-1:0]    status;
	logic [topq_pkg::CountFieldW-1:0]     entry_count;

	modport source (output valid, result_id, result_time, id_found, status, entry_count,
		input ready);
	modport sink (input valid, result_id, result_time, id_found, status, entry_count,
		output ready);
endinterface

// ===== rtl/topq_cell.sv =====
module topq_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned IDW   = 16,
	parameter int unsigned TW    = 32,
	parameter int unsigned CNT_W = 6
) (
	input  logic                clk,
	input  topq_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]    cnt,
	input  logic [IDW-1:0]      key_id,
	input  logic [TW-1:0]       key_tm,
	input  logic                prv_le,
	input  logic [IDW-1:0]      prv_id,
	input  logic [TW-1:0]       prv_tm,
	input  logic [IDW-1:0]      nxt_id,
	input  logic [TW-1:0]       nxt_tm,
	input  logic                hit_in,
	output logic                le,
	output logic                hit_out,
	output logic [IDW-1:0]      id_q,
	output logic [TW-1:0]       tm_q,
	output logic [IDW-1:0]      id_d,
	output logic [TW-1:0]       tm_d
);

	logic vld;
	logic match;

	assign vld     = cnt > CNT_W'(IDX);
	assign le      = vld && (tm_q <= key_tm);
	assign match   = vld && (id_q == key_id);
	assign hit_out = hit_in || match;

	always_comb begin
		id_d = id_q;
		tm_d = tm_q;
		if (ctl.fire) begin
			case (ctl.op)
				topq_pkg::OP_ENQ: begin
					if (!ctl.full && !le) begin
						if (prv_le) begin
							id_d = key_id;
							tm_d = key_tm;
						end else begin
							id_d = prv_id;
							tm_d = prv_tm;
						end
					end
				end
				topq_pkg::OP_DEQ: begin
					id_d = nxt_id;
					tm_d = nxt_tm;
				end
				topq_pkg::OP_REMOVE: begin
					if (hit_out) begin
						id_d = nxt_id;
						tm_d = nxt_tm;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
		tm_q <= tm_d;
	end

endmodule

// ===== rtl/time_ordered_priority_queue_core.sv =====
// Time-ordered priority queue: up to QUEUE_DEPTH entries of id and time held in a row of
// cells, sorted by rising time with ties kept in arrival order. Each request (enqueue,
// dequeue, lookup, remove) is resolved in parallel: every cell compares its entry with the
// request key and loads from itself, the key or its left or right neighbour, so an item
// is taken every cycle while the output register can take it, and its response appears
// in that register in the next cycle. A request is taken whenever that register is empty
// or being drained in the same cycle. Responses carry the count and head entry after the
// operation (dequeue: entry taken); ids/times hold min(ID_BITS,16)/min(TIME_BITS,32) bits.
module time_ordered_priority_queue_core #(
	parameter int unsigned QUEUE_DEPTH = 32,
	parameter int unsigned ID_BITS     = 16,
	parameter int unsigned TIME_BITS   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	topq_req_if.sink  req,
	topq_rsp_if.source rsp
);

	localparam int unsigned IDW = (ID_BITS < topq_pkg::IdFieldW) ? ID_BITS
		: topq_pkg::IdFieldW;
	localparam int unsigned TW = (TIME_BITS < topq_pkg::TimeFieldW) ? TIME_BITS
		: topq_pkg::TimeFieldW;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned CW_MAX = (CNT_W > topq_pkg::CountFieldW) ? CNT_W
		: topq_pkg::CountFieldW;

	topq_pkg::cell_ctl_t ctl;
	topq_pkg::op_t       op;
	topq_pkg::status_t   status;
	logic                fire;
	logic                empty;
	logic                found;
	logic                deq_ok;
	logic [IDW-1:0]      key_id;
	logic [TW-1:0]       key_tm;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic [CW_MAX-1:0]   cnt_wide;
	logic [IDW-1:0]      res_id;
	logic [TW-1:0]       res_tm;

	logic [QUEUE_DEPTH-1:0] le_a;
	logic [QUEUE_DEPTH-1:0] hit_a;
	logic [IDW-1:0]         id_q_a [QUEUE_DEPTH];
	logic [TW-1:0]          tm_q_a [QUEUE_DEPTH];
	logic [IDW-1:0]         id_d_a [QUEUE_DEPTH];
	logic [TW-1:0]          tm_d_a [QUEUE_DEPTH];

	logic                               out_valid_q;
	logic [topq_pkg::IdFieldW-1:0]      out_id_q;
	logic [topq_pkg::TimeFieldW-1:0]    out_tm_q;
	logic                               out_found_q;
	topq_pkg::status_t                  out_status_q;
	logic [topq_pkg::CountFieldW-1:0]   out_cnt_q;

	assign req.ready = !out_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign op        = topq_pkg::op_t'(req.action);
	assign key_id    = req.entry_id[IDW-1:0];
	assign key_tm    = req.entry_time[TW-1:0];
	assign empty     = (cnt_q == '0);

	assign ctl.fire = fire;
	assign ctl.op   = op;
	assign ctl.full = (cnt_q == CNT_W'(QUEUE_DEPTH));

	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic           prv_le;
		logic [IDW-1:0] prv_id;
		logic [TW-1:0]  prv_tm;
		logic [IDW-1:0] nxt_id;
		logic [TW-1:0]  nxt_tm;
		logic           hit_in;

		if (k == 0) begin : g_first
			assign prv_le = 1'b1;
			assign prv_id = '0;
			assign prv_tm = '0;
			assign hit_in = 1'b0;
		end else begin : g_mid
			assign prv_le = le_a[k-1];
			assign prv_id = id_q_a[k-1];
			assign prv_tm = tm_q_a[k-1];
			assign hit_in = hit_a[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_id = '0;
			assign nxt_tm = '0;
		end else begin : g_inner
			assign nxt_id = id_q_a[k+1];
			assign nxt_tm = tm_q_a[k+1];
		end

		topq_cell #(
			.IDX   (k),
			.IDW   (IDW),
			.TW    (TW),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.cnt     (cnt_q),
			.key_id  (key_id),
			.key_tm  (key_tm),
			.prv_le  (prv_le),
			.prv_id  (prv_id),
			.prv_tm  (prv_tm),
			.nxt_id  (nxt_id),
			.nxt_tm  (nxt_tm),
			.hit_in  (hit_in),
			.le      (le_a[k]),
			.hit_out (hit_a[k]),
			.id_q    (id_q_a[k]),
			.tm_q    (tm_q_a[k]),
			.id_d    (id_d_a[k]),
			.tm_d    (tm_d_a[k])
		);
	end

	assign found  = hit_a[QUEUE_DEPTH-1];
	assign deq_ok = (op == topq_pkg::OP_DEQ) && !empty;

	always_comb begin
		cnt_d  = cnt_q;
		status = topq_pkg::ST_OK;
		case (op)
			topq_pkg::OP_ENQ: begin
				if (ctl.full) begin
					status = topq_pkg::ST_FULL;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			topq_pkg::OP_DEQ: begin
				if (empty) begin
					status = topq_pkg::ST_EMPTY;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			topq_pkg::OP_LOOKUP: begin
				if (!found) begin
					status = topq_pkg::ST_NOT_FOUND;
				end
			end
			topq_pkg::OP_REMOVE: begin
				if (!found) begin
					status = topq_pkg::ST_NOT_FOUND;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (deq_ok) begin
			res_id = id_q_a[0];
			res_tm = tm_q_a[0];
		end else if (cnt_d != '0) begin
			res_id = id_d_a[0];
			res_tm = tm_d_a[0];
		end else begin
			res_id = '0;
			res_tm = '0;
		end
	end

	assign cnt_wide = CW_MAX'(cnt_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_id_q     <= topq_pkg::IdFieldW'(res_id);
			out_tm_q     <= topq_pkg::TimeFieldW'(res_tm);
			out_found_q  <= found && ((op == topq_pkg::OP_LOOKUP) || (op == topq_pkg::OP_REMOVE));
			out_status_q <= status;
			out_cnt_q    <= cnt_wide[topq_pkg::CountFieldW-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_id   = out_id_q;
	assign rsp.result_time = out_tm_q;
	assign rsp.id_found    = out_found_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_count = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op == topq_pkg::OP_ENQ) && ctl.full |=> $stable(cnt_q))
		else $error("refused enqueue changed the count");

	a_deq_dec: assert property (@(posedge clk) disable iff (!arst_n)
		fire && deq_ok |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("dequeue did not drop one entry");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("accepted item produced no response");

	a_miss_keep: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !found && ((op == topq_pkg::OP_LOOKUP) || (op == topq_pkg::OP_REMOVE))
		|=> $stable(cnt_q))
		else $error("missed id changed the count");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import topq_pkg::*;

	localparam int unsigned QueueDepth = 32;

	typedef struct {
		logic [IdFieldW-1:0]   id;
		logic [TimeFieldW-1:0] tstamp;
	} entry_t;

	typedef struct {
		logic [IdFieldW-1:0]    id;
		logic [TimeFieldW-1:0]  tstamp;
		logic                   found;
		status_t                status;
		logic [CountFieldW-1:0] count;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	topq_req_if req_ch ();
	topq_rsp_if rsp_ch ();

	time_ordered_priority_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	entry_t      held_q[$];
	outcome_t    outcome_q[$];
	int unsigned fail_count = 0;
	int unsigned gap_max = 0;
	int unsigned stall_max = 0;
	int unsigned stall_left = 0;

	always #5 clk = ~clk;

	function automatic outcome_t apply_request(op_t op, logic [IdFieldW-1:0] id,
			logic [TimeFieldW-1:0] tm);
		outcome_t r;
		entry_t   e;
		int       pos;
		logic     dequeued;
		r.id = '0;
		r.tstamp = '0;
		r.found = 1'b0;
		r.status = ST_OK;
		dequeued = 1'b0;
		case (op)
			OP_ENQ: begin
				if (held_q.size() >= QueueDepth) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < held_q.size() && held_q[pos].tstamp <= tm)
						pos++;
					e.id = id;
					e.tstamp = tm;
					held_q.insert(pos, e);
				end
			end
			OP_DEQ: begin
				if (held_q.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					e = held_q.pop_front();
					r.id = e.id;
					r.tstamp = e.tstamp;
					dequeued = 1'b1;
				end
			end
			default: begin
				pos = -1;
				for (int k = 0; k < held_q.size(); k++) begin
					if (pos < 0 && held_q[k].id == id)
						pos = k;
				end
				if (pos < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.found = 1'b1;
					if (op == OP_REMOVE)
						held_q.delete(pos);
				end
			end
		endcase
		if (!dequeued && held_q.size() > 0) begin
			r.id = held_q[0].id;
			r.tstamp = held_q[0].tstamp;
		end
		r.count = CountFieldW'(held_q.size());
		return r;
	endfunction

	function automatic logic [IdFieldW-1:0] rand_id();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return IdFieldW'($urandom_range(0, 7));
		if (r < 55)
			return '1;
		return IdFieldW'($urandom);
	endfunction

	function automatic logic [IdFieldW-1:0] pick_key_id();
		if (held_q.size() > 0 && $urandom_range(0, 99) < 60)
			return held_q[$urandom_range(0, held_q.size() - 1)].id;
		return rand_id();
	endfunction

	function automatic logic [TimeFieldW-1:0] rand_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return TimeFieldW'($urandom_range(0, 15));
		if (r < 35)
			return '0;
		if (r < 40)
			return '1;
		return TimeFieldW'($urandom);
	endfunction

	task automatic send_item(op_t op, logic [IdFieldW-1:0] id, logic [TimeFieldW-1:0] tm);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= op;
		req_ch.entry_id <= id;
		req_ch.entry_time <= tm;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		outcome_q.push_back(apply_request(op, id, tm));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_item();
		int unsigned r;
		int unsigned enq_share;
		r = $urandom_range(0, 99);
		enq_share = (held_q.size() < QueueDepth / 2) ? 45 : 30;
		if (r < enq_share)
			send_item(OP_ENQ, rand_id(), rand_time());
		else if (r < enq_share + 25)
			send_item(OP_DEQ, rand_id(), TimeFieldW'($urandom));
		else if (r < enq_share + 45)
			send_item(OP_LOOKUP, pick_key_id(), TimeFieldW'($urandom));
		else
			send_item(OP_REMOVE, pick_key_id(), TimeFieldW'($urandom));
	endtask

	task automatic test_empty_queue();
		send_item(OP_DEQ, '0, '0);
		send_item(OP_LOOKUP, '0, '1);
		send_item(OP_REMOVE, '1, '0);
		send_item(OP_ENQ, 16'd5, 32'd100);
		send_item(OP_DEQ, '1, '1);
		send_item(OP_LOOKUP, 16'd5, '0);
	endtask

	task automatic test_order_and_ties();
		send_item(OP_ENQ, '1, '1);
		send_item(OP_ENQ, '0, '0);
		send_item(OP_ENQ, 16'd7, 32'd50);
		send_item(OP_ENQ, 16'd8, 32'd50);
		send_item(OP_ENQ, 16'd7, 32'd50);
		send_item(OP_ENQ, 16'd9, '0);
		send_item(OP_LOOKUP, 16'd7, '0);
		send_item(OP_LOOKUP, 16'd3, '0);
		send_item(OP_REMOVE, 16'd7, '0);
		send_item(OP_LOOKUP, 16'd7, '0);
		send_item(OP_REMOVE, 16'd3, '0);
		send_item(OP_REMOVE, '1, '0);
		repeat (5)
			send_item(OP_DEQ, '0, '0);
	endtask

	task automatic test_full_queue(int unsigned rounds);
		repeat (rounds) begin
			while (held_q.size() < QueueDepth)
				send_item(OP_ENQ, rand_id(), rand_time());
			repeat (3)
				send_item(OP_ENQ, rand_id(), rand_time());
			send_item(OP_LOOKUP, pick_key_id(), '0);
			send_item(OP_REMOVE, pick_key_id(), '0);
			while (held_q.size() < QueueDepth)
				send_item(OP_ENQ, rand_id(), rand_time());
			send_item(OP_ENQ, '1, '0);
			while (held_q.size() > 0)
				send_item(OP_DEQ, rand_id(), '0);
			send_item(OP_DEQ, '0, '1);
		end
	endtask

	task automatic test_random_mix(int unsigned n);
		repeat (n)
			send_random_item();
	endtask

	task automatic test_pause_for_results();
		repeat (3) begin
			repeat (15)
				send_random_item();
			drain_results();
		end
	endtask

	always @(posedge clk) begin : rsp_check
		outcome_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcome_q.size() == 0) begin
					$error("result item with none outstanding");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (rsp_ch.result_id !== want.id) begin
						$error("result_id: expected %0h, got %0h", want.id, rsp_ch.result_id);
						fail_count++;
					end
					if (rsp_ch.result_time !== want.tstamp) begin
						$error("result_time: expected %0h, got %0h", want.tstamp,
							rsp_ch.result_time);
						fail_count++;
					end
					if (rsp_ch.id_found !== want.found) begin
						$error("id_found: expected %0d, got %0d", want.found, rsp_ch.id_found);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.entry_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count,
							rsp_ch.entry_count);
						fail_count++;
					end
				end
				stall_left = $urandom_range(0, stall_max);
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.action = OP_ENQ;
		req_ch.entry_id = '0;
		req_ch.entry_time = '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		gap_max = 3;
		stall_max = 3;
		test_order_and_ties();

		gap_max = 6;
		stall_max = 6;
		test_full_queue(3);

		gap_max = 0;
		stall_max = 0;
		test_random_mix(150);
		gap_max = 6;
		test_random_mix(150);
		gap_max = 0;
		stall_max = 6;
		test_random_mix(150);
		gap_max = 6;
		test_random_mix(150);

		gap_max = 2;
		test_pause_for_results();

		drain_results();
		repeat (4)
			@(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
